// ===== rtl/ffa_pkg.sv =====
// ffa_pkg: shared constants, result codes, fsm states and the command/status
// structs that join the allocator controller and datapath. no dependencies.
package ffa_pkg;

    localparam int unsigned ARENA_BYTES = 1024 * 64;
    localparam int unsigned ALIGN_BYTES = 16;
    localparam int unsigned HDR_BYTES   = 16;
    localparam int unsigned SPLIT_SLACK = 16;

    localparam int unsigned ALIGN_SHIFT = $clog2(ALIGN_BYTES);
    localparam int unsigned HDR_ALIGNED =
        ((HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int unsigned HDR_GRANS   = HDR_ALIGNED / ALIGN_BYTES;
    localparam int unsigned SPLIT_GRANS =
        (HDR_ALIGNED + SPLIT_SLACK + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int unsigned GRAN_COUNT  = ARENA_BYTES / ALIGN_BYTES;
    localparam int unsigned ADDR_W      = $clog2(GRAN_COUNT);
    localparam int unsigned IDX_W       = $clog2(GRAN_COUNT + 1);
    localparam int unsigned NULL_IDX    = GRAN_COUNT;

    localparam int unsigned BYTES_W  = 17;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned NEED_W   = BYTES_W + 1;

    typedef enum logic [1:0] {
        RES_GRANTED  = 2'd0,
        RES_NOFIT    = 2'd1,
        RES_RELEASED = 2'd2,
        RES_IGNORED  = 2'd3
    } ffa_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK,
        ST_CHECK,
        ST_SPLIT,
        ST_DONE
    } ffa_state_t;

    typedef struct packed {
        logic        start;
        logic        rd;
        logic        advance;
        logic        split_a;
        logic        split_b;
        logic        unlink;
        logic        release_wr;
        logic        set_code;
        ffa_result_t code;
        logic        result_load;
    } ffa_cmd_t;

    typedef struct packed {
        logic is_release;
        logic rel_ok;
        logic walk_end;
        logic fit;
        logic split_ok;
        logic out_free;
    } ffa_stat_t;

endpackage

// ===== rtl/ffa_ctrl.sv =====
// ffa_ctrl: allocator state machine, sequences header reads and writes.
// depends on ffa_pkg for states, result codes and the cmd/status structs.
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_cmd_t  cmd
);
    import ffa_pkg::*;

    ffa_state_t state_reg;
    ffa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = RES_GRANTED;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_release)
                begin
                    cmd.set_code = 1'b1;
                    if (stat.rel_ok)
                    begin
                        cmd.release_wr = 1'b1;
                        cmd.code       = RES_RELEASED;
                    end
                    else
                    begin
                        cmd.code = RES_IGNORED;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_end)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = RES_NOFIT;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.fit)
                begin
                    if (stat.split_ok)
                    begin
                        cmd.split_a = 1'b1;
                        state_next  = ST_SPLIT;
                    end
                    else
                    begin
                        cmd.unlink   = 1'b1;
                        cmd.set_code = 1'b1;
                        cmd.code     = RES_GRANTED;
                        state_next   = ST_DONE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_SPLIT:
            begin
                cmd.split_b  = 1'b1;
                cmd.set_code = 1'b1;
                cmd.code     = RES_GRANTED;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ffa_datapath.sv =====
// ffa_datapath: request latch, walk pointers, list head, header memories
// and the result register. depends on ffa_pkg.
module ffa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           mode,
    input  logic [ffa_pkg::BYTES_W-1:0]    request_bytes,
    input  logic [ffa_pkg::OFFSET_W-1:0]   release_offset,
    input  ffa_pkg::ffa_cmd_t              cmd,
    output ffa_pkg::ffa_stat_t             stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [ffa_pkg::OFFSET_W-1:0]   payload_offset
);
    import ffa_pkg::*;

    // header store, split in size and next halves
    logic [IDX_W-1:0] size_mem [GRAN_COUNT];
    logic [IDX_W-1:0] next_mem [GRAN_COUNT];

    logic                mode_reg;
    logic [NEED_W-1:0]   need_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    prev_reg;
    logic [IDX_W-1:0]    visits_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    ffa_result_t         code_reg;

    logic [IDX_W-1:0]    rd_size_reg;
    logic [IDX_W-1:0]    rd_next_reg;
    logic                rd_size0_reg;
    logic                rd_next0_reg;
    logic                size0_vld_reg;
    logic                next0_vld_reg;

    logic                out_valid_reg;
    ffa_result_t         status_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic [NEED_W-1:0]   need_calc;
    logic [IDX_W-1:0]    sz;
    logic [IDX_W-1:0]    nxt;
    logic [NEED_W-1:0]   tail_sum;
    logic [IDX_W-1:0]    tail;
    logic [OFFSET_W-1:0] rel_diff;
    logic [OFFSET_W-1:0] rel_gran;
    logic [IDX_W-1:0]    rel_idx;
    logic                prev_null;
    logic [OFFSET_W-1:0] grant_off;

    logic                size_we;
    logic [ADDR_W-1:0]   size_waddr;
    logic [IDX_W-1:0]    size_wdata;
    logic                next_we;
    logic [ADDR_W-1:0]   next_waddr;
    logic [IDX_W-1:0]    next_wdata;

    assign need_calc = ((NEED_W'(request_bytes) + NEED_W'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT)
                       + NEED_W'(HDR_GRANS);
    assign sz        = rd_size0_reg ? IDX_W'(GRAN_COUNT) : rd_size_reg;
    assign nxt       = rd_next0_reg ? IDX_W'(NULL_IDX) : rd_next_reg;
    assign tail_sum  = NEED_W'(cur_reg) + need_reg;
    assign tail      = tail_sum[IDX_W-1:0];
    assign rel_diff  = off_reg - OFFSET_W'(HDR_ALIGNED);
    assign rel_gran  = rel_diff >> ALIGN_SHIFT;
    assign rel_idx   = IDX_W'(rel_gran);
    assign prev_null = (prev_reg == IDX_W'(NULL_IDX));
    assign grant_off = OFFSET_W'((32'(cur_reg) * ALIGN_BYTES) + HDR_ALIGNED);

    always_comb
    begin
        stat.is_release = mode_reg;
        stat.rel_ok     = (off_reg >= OFFSET_W'(HDR_ALIGNED))
                          && (32'(rel_gran) < GRAN_COUNT);
        stat.walk_end   = (cur_reg >= IDX_W'(NULL_IDX))
                          || (visits_reg == IDX_W'(GRAN_COUNT));
        stat.fit        = (NEED_W'(sz) >= need_reg);
        stat.split_ok   = (NEED_W'(sz) >= need_reg + NEED_W'(SPLIT_GRANS))
                          && (tail_sum < NEED_W'(GRAN_COUNT));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // memory write port muxing, one write per memory per cycle
    always_comb
    begin
        size_we    = 1'b0;
        size_waddr = cur_reg[ADDR_W-1:0];
        size_wdata = need_reg[IDX_W-1:0];
        next_we    = 1'b0;
        next_waddr = prev_reg[ADDR_W-1:0];
        next_wdata = nxt;
        head_next  = head_reg;
        if (cmd.split_a)
        begin
            size_we    = 1'b1;
            size_waddr = tail[ADDR_W-1:0];
            size_wdata = sz - need_reg[IDX_W-1:0];
            next_we    = 1'b1;
            next_waddr = tail[ADDR_W-1:0];
            next_wdata = nxt;
        end
        else if (cmd.split_b)
        begin
            size_we    = 1'b1;
            size_waddr = cur_reg[ADDR_W-1:0];
            size_wdata = need_reg[IDX_W-1:0];
            next_wdata = tail;
            if (prev_null)
            begin
                head_next = tail;
            end
            else
            begin
                next_we = 1'b1;
            end
        end
        else if (cmd.unlink)
        begin
            next_wdata = nxt;
            if (prev_null)
            begin
                head_next = nxt;
            end
            else
            begin
                next_we = 1'b1;
            end
        end
        else if (cmd.release_wr)
        begin
            next_we    = 1'b1;
            next_waddr = rel_idx[ADDR_W-1:0];
            next_wdata = head_reg;
            head_next  = rel_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.rd)
        begin
            rd_size_reg <= size_mem[cur_reg[ADDR_W-1:0]];
            rd_next_reg <= next_mem[cur_reg[ADDR_W-1:0]];
        end
    end

    // entry zero holds the whole arena until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size0_vld_reg <= 1'b0;
            next0_vld_reg <= 1'b0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (size_we && (size_waddr == '0))
            begin
                size0_vld_reg <= 1'b1;
            end
            if (next_we && (next_waddr == '0))
            begin
                next0_vld_reg <= 1'b1;
            end
            head_reg <= head_next;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg   <= mode;
            need_reg   <= need_calc;
            off_reg    <= release_offset;
            cur_reg    <= head_reg;
            prev_reg   <= IDX_W'(NULL_IDX);
            visits_reg <= '0;
        end
        else if (cmd.advance)
        begin
            prev_reg   <= cur_reg;
            cur_reg    <= nxt;
            visits_reg <= visits_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            rd_size0_reg <= (cur_reg[ADDR_W-1:0] == '0) && !size0_vld_reg;
            rd_next0_reg <= (cur_reg[ADDR_W-1:0] == '0) && !next0_vld_reg;
        end
        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.result_load)
        begin
            status_reg <= code_reg;
            offset_reg <= (code_reg == RES_GRANTED) ? grant_off : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign payload_offset = offset_reg;

endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// first_fit_free_list_allocator: top level, joins ffa_ctrl and ffa_datapath.
// depends on ffa_pkg.
//
//  channel | signals                                                | direction
//  in      | in_valid in_ready mode request_bytes release_offset    | into block
//  out     | out_valid out_ready status payload_offset              | out of block
//
// release: the dispatch state, then the done state loads the result register.
// allocate: dispatch, then a walk and a check state per header visited, then a split state
// for a split or a last walk state for a no-fit end; each visit reads both header memories.
// reset leaves the whole arena as one free block at granule zero, no clearing pass.
// a finished result holds the state machine until the output register frees;
// in_ready returns the cycle after the result is loaded.
module first_fit_free_list_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [ffa_pkg::BYTES_W-1:0]  request_bytes,
    input  logic [ffa_pkg::OFFSET_W-1:0] release_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [ffa_pkg::OFFSET_W-1:0] payload_offset
);
    import ffa_pkg::*;

    ffa_cmd_t  cmd;
    ffa_stat_t stat;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffa_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .payload_offset (payload_offset)
    );

endmodule

// ===== rtl/ffa_checker.sv =====
// ffa_checker: port-level assertions for the allocator, bound to the top.
// depends on ffa_pkg.
module ffa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         mode,
    input logic [ffa_pkg::BYTES_W-1:0]  request_bytes,
    input logic [ffa_pkg::OFFSET_W-1:0] release_offset,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   status,
    input logic [ffa_pkg::OFFSET_W-1:0] payload_offset
);
    import ffa_pkg::*;

    // offered beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(request_bytes)
                                  && $stable(release_offset))
        else $error("input beat changed while stalled");

    // held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(payload_offset))
        else $error("result beat changed while stalled");

    // only a grant carries an offset
    a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != RES_GRANTED) |-> payload_offset == '0)
        else $error("offset nonzero without grant");

    // granted offsets sit on a granule boundary
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == RES_GRANTED)
        |-> (payload_offset & OFFSET_W'(ALIGN_BYTES - 1)) == '0)
        else $error("granted offset misaligned");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);
